@@ rtl/tsf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared types, microcode layout and the microcode program of the
// triangle scanline filler.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int PAINT_W = 4;
  localparam int PC_W    = 4;

  // step addresses of the microcode program
  localparam logic [PC_W-1:0] STEP_WAIT      = 4'd0;
  localparam logic [PC_W-1:0] STEP_DISPATCH  = 4'd1;
  localparam logic [PC_W-1:0] STEP_SORT_AB   = 4'd2;
  localparam logic [PC_W-1:0] STEP_SORT_AC   = 4'd3;
  localparam logic [PC_W-1:0] STEP_SORT_BC   = 4'd4;
  localparam logic [PC_W-1:0] STEP_CHECK     = 4'd5;
  localparam logic [PC_W-1:0] STEP_DIV_LONG  = 4'd6;
  localparam logic [PC_W-1:0] STEP_WAIT_LONG = 4'd7;
  localparam logic [PC_W-1:0] STEP_DIV_UPPER = 4'd8;
  localparam logic [PC_W-1:0] STEP_WAIT_UPR  = 4'd9;
  localparam logic [PC_W-1:0] STEP_DIV_LOWER = 4'd10;
  localparam logic [PC_W-1:0] STEP_WAIT_LWR  = 4'd11;
  localparam logic [PC_W-1:0] STEP_INIT      = 4'd12;
  localparam logic [PC_W-1:0] STEP_DROP      = 4'd13;
  localparam logic [PC_W-1:0] STEP_SPAN      = 4'd14;
  localparam logic [PC_W-1:0] STEP_EMIT      = 4'd15;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    JC_NONE      = 3'd0,
    JC_ALWAYS    = 3'd1,
    JC_NO_ACCEPT = 3'd2,
    JC_OP_STEP   = 3'd3,
    JC_FLAT      = 3'd4,
    JC_DIV_BUSY  = 3'd5,
    JC_IDLE      = 3'd6
  } jmp_cond_e;

  typedef enum logic [1:0] {
    VOP_NONE    = 2'd0,
    VOP_SWAP_AB = 2'd1,
    VOP_SWAP_AC = 2'd2,
    VOP_SWAP_BC = 2'd3
  } vop_e;

  typedef enum logic [1:0] {
    SL_NONE  = 2'd0,
    SL_LONG  = 2'd1,
    SL_UPPER = 2'd2,
    SL_LOWER = 2'd3
  } slope_sel_e;

  typedef struct packed {
    jmp_cond_e       cond;
    logic [PC_W-1:0] target;
    logic            take;
    vop_e            vop;
    logic            div_start;
    slope_sel_e      div_sel;
    slope_sel_e      slope_wr;
    logic            init;
    logic            drop;
    logic            emit;
  } ctl_word_t;

  typedef struct packed {
    logic accept;
    logic op_step;
    logic flat;
    logic div_busy;
    logic busy;
  } seq_status_t;

  function automatic ctl_word_t ucode(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    w = '0;
    unique case (pc)
      STEP_WAIT: begin
        w.take   = 1'b1;
        w.cond   = JC_NO_ACCEPT;
        w.target = STEP_WAIT;
      end
      STEP_DISPATCH: begin
        w.cond   = JC_OP_STEP;
        w.target = STEP_SPAN;
      end
      STEP_SORT_AB: w.vop = VOP_SWAP_AB;
      STEP_SORT_AC: w.vop = VOP_SWAP_AC;
      STEP_SORT_BC: w.vop = VOP_SWAP_BC;
      STEP_CHECK: begin
        w.cond   = JC_FLAT;
        w.target = STEP_DROP;
      end
      STEP_DIV_LONG: begin
        w.div_start = 1'b1;
        w.div_sel   = SL_LONG;
      end
      STEP_WAIT_LONG: begin
        w.cond   = JC_DIV_BUSY;
        w.target = STEP_WAIT_LONG;
      end
      STEP_DIV_UPPER: begin
        w.slope_wr  = SL_LONG;
        w.div_start = 1'b1;
        w.div_sel   = SL_UPPER;
      end
      STEP_WAIT_UPR: begin
        w.cond   = JC_DIV_BUSY;
        w.target = STEP_WAIT_UPR;
      end
      STEP_DIV_LOWER: begin
        w.slope_wr  = SL_UPPER;
        w.div_start = 1'b1;
        w.div_sel   = SL_LOWER;
      end
      STEP_WAIT_LWR: begin
        w.cond   = JC_DIV_BUSY;
        w.target = STEP_WAIT_LWR;
      end
      STEP_INIT: begin
        w.slope_wr = SL_LOWER;
        w.init     = 1'b1;
        w.cond     = JC_ALWAYS;
        w.target   = STEP_WAIT;
      end
      STEP_DROP: begin
        w.drop   = 1'b1;
        w.cond   = JC_ALWAYS;
        w.target = STEP_WAIT;
      end
      STEP_SPAN: begin
        w.cond   = JC_IDLE;
        w.target = STEP_WAIT;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = JC_ALWAYS;
        w.target = STEP_WAIT;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ rtl/tsf_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_in_if
// Command channel: load a triangle or request the next span.
// ----------------------------------------------------------------------------
interface tsf_in_if #(
  parameter int COORD_BITS = 8
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [COORD_BITS-1:0]        vx_a;
  logic [COORD_BITS-1:0]        vy_a;
  logic [COORD_BITS-1:0]        vx_b;
  logic [COORD_BITS-1:0]        vy_b;
  logic [COORD_BITS-1:0]        vx_c;
  logic [COORD_BITS-1:0]        vy_c;
  logic [tsf_pkg::PAINT_W-1:0]  paint;

  modport source (
    output valid, opcode, vx_a, vy_a, vx_b, vy_b, vx_c, vy_c, paint,
    input  ready
  );
  modport sink (
    input  valid, opcode, vx_a, vy_a, vx_b, vy_b, vx_c, vy_c, paint,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/tsf_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_out_if
// Span channel: one horizontal span per transaction.
// ----------------------------------------------------------------------------
interface tsf_out_if #(
  parameter int COORD_BITS = 8
);
  logic                         valid;
  logic                         ready;
  logic [COORD_BITS-1:0]        span_row;
  logic [COORD_BITS-1:0]        span_left;
  logic [COORD_BITS:0]          span_width;
  logic [tsf_pkg::PAINT_W-1:0]  span_paint;
  logic                         final_span;

  modport source (
    output valid, span_row, span_left, span_width, span_paint, final_span,
    input  ready
  );
  modport sink (
    input  valid, span_row, span_left, span_width, span_paint, final_span,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/tsf_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_divider
// Restoring sign-magnitude divider, one quotient bit per cycle, truncating
// toward zero. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module tsf_divider #(
  parameter int NUM_W = 14,
  parameter int DEN_W = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic                    neg_i,
  input  wire logic [NUM_W-1:0]        num_i,
  input  wire logic [DEN_W-1:0]        den_i,
  output logic                         busy_o,
  output logic signed [NUM_W+1:0]      quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic             neg_q;
  logic             zero_q;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [NUM_W+1:0] mag;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign diff   = rem_sh - {1'b0, den_q};
  assign mag    = {2'b00, quo_q};
  assign busy_o = cnt_q != '0;

  always_comb begin
    if (zero_q) begin
      quot_o = '0;
    end else if (neg_q) begin
      quot_o = -$signed(mag);
    end else begin
      quot_o = $signed(mag);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
      neg_q  <= neg_i;
      zero_q <= den_i == '0;
    end else if (busy_o) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/tsf_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_sequencer
// Step counter over the microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
module tsf_sequencer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tsf_pkg::seq_status_t status_i,
  output tsf_pkg::ctl_word_t        ctl_o
);

  logic [tsf_pkg::PC_W-1:0] pc_q, pc_d;
  logic                     jump;

  assign ctl_o = tsf_pkg::ucode(pc_q);

  always_comb begin
    unique case (ctl_o.cond)
      tsf_pkg::JC_NONE:      jump = 1'b0;
      tsf_pkg::JC_ALWAYS:    jump = 1'b1;
      tsf_pkg::JC_NO_ACCEPT: jump = !status_i.accept;
      tsf_pkg::JC_OP_STEP:   jump = status_i.op_step;
      tsf_pkg::JC_FLAT:      jump = status_i.flat;
      tsf_pkg::JC_DIV_BUSY:  jump = status_i.div_busy;
      tsf_pkg::JC_IDLE:      jump = !status_i.busy;
      default:               jump = 1'b1;
    endcase
  end

  assign pc_d = jump ? ctl_o.target : pc_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tsf_pkg::STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tsf_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_datapath
// Vertex registers with compare-swap, slope divider, edge accumulators and
// the span output register, all steered by the microcode word.
// ----------------------------------------------------------------------------
module tsf_datapath #(
  parameter int COORD_BITS = 8,
  parameter int FRAC_BITS  = 6
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tsf_pkg::ctl_word_t           ctl_i,
  output tsf_pkg::seq_status_t              status_o,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         in_opcode_i,
  input  wire logic [COORD_BITS-1:0]        in_vx_a_i,
  input  wire logic [COORD_BITS-1:0]        in_vy_a_i,
  input  wire logic [COORD_BITS-1:0]        in_vx_b_i,
  input  wire logic [COORD_BITS-1:0]        in_vy_b_i,
  input  wire logic [COORD_BITS-1:0]        in_vx_c_i,
  input  wire logic [COORD_BITS-1:0]        in_vy_c_i,
  input  wire logic [tsf_pkg::PAINT_W-1:0]  in_paint_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [COORD_BITS-1:0]             span_row_o,
  output logic [COORD_BITS-1:0]             span_left_o,
  output logic [COORD_BITS:0]               span_width_o,
  output logic [tsf_pkg::PAINT_W-1:0]       span_paint_o,
  output logic                              final_span_o
);

  localparam int NUM_W = COORD_BITS + FRAC_BITS;
  localparam int POS_W = COORD_BITS + FRAC_BITS + 2;

  // captured command and vertices (sorted in place)
  logic                        op_q;
  logic [COORD_BITS-1:0]       xa_q, ya_q, xb_q, yb_q, xc_q, yc_q;
  logic [tsf_pkg::PAINT_W-1:0] paint_in_q;

  // triangle state
  logic                        busy_q;
  logic [COORD_BITS-1:0]       cur_row_q, mid_row_q, end_row_q, mid_col_q;
  logic signed [POS_W-1:0]     long_pos_q, short_pos_q;
  logic signed [POS_W-1:0]     long_slope_q, upper_slope_q, lower_slope_q;
  logic [tsf_pkg::PAINT_W-1:0] fill_paint_q;

  // output register
  logic                        out_valid_q;
  logic [COORD_BITS-1:0]       row_out_q, left_out_q;
  logic [COORD_BITS:0]         width_out_q;
  logic [tsf_pkg::PAINT_W-1:0] paint_out_q;
  logic                        final_out_q;

  logic accept;

  // divider operands
  logic [COORD_BITS-1:0]   dx_lo, dx_hi, dy_lo, dy_hi;
  logic signed [COORD_BITS:0] dx;
  logic [COORD_BITS:0]     dx_abs;
  logic [NUM_W-1:0]        num;
  logic [COORD_BITS-1:0]   den;
  logic                    div_busy;
  logic signed [POS_W-1:0] quot;

  // span logic
  logic signed [POS_W-1:0] short_eff;
  logic [COORD_BITS-1:0]   long_int, short_int, span_lo, span_hi;
  logic                    last_row;

  assign in_ready_o = ctl_i.take && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign status_o.accept   = accept;
  assign status_o.op_step  = op_q == tsf_pkg::OP_STEP;
  assign status_o.flat     = ya_q == yc_q;
  assign status_o.div_busy = div_busy;
  assign status_o.busy     = busy_q;

  always_comb begin
    unique case (ctl_i.div_sel)
      tsf_pkg::SL_UPPER: begin
        dx_lo = xa_q; dx_hi = xb_q; dy_lo = ya_q; dy_hi = yb_q;
      end
      tsf_pkg::SL_LOWER: begin
        dx_lo = xb_q; dx_hi = xc_q; dy_lo = yb_q; dy_hi = yc_q;
      end
      default: begin
        dx_lo = xa_q; dx_hi = xc_q; dy_lo = ya_q; dy_hi = yc_q;
      end
    endcase
  end

  assign dx     = $signed({1'b0, dx_hi}) - $signed({1'b0, dx_lo});
  assign dx_abs = dx[COORD_BITS] ? -dx : dx;
  assign num    = {dx_abs[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign den    = dy_hi - dy_lo;

  tsf_divider #(
    .NUM_W (NUM_W),
    .DEN_W (COORD_BITS)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.div_start),
    .neg_i   (dx[COORD_BITS]),
    .num_i   (num),
    .den_i   (den),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // reload the short edge from the middle vertex on the middle row
  assign short_eff = (cur_row_q == mid_row_q)
                   ? $signed({2'b00, mid_col_q, {FRAC_BITS{1'b0}}})
                   : short_pos_q;
  assign long_int  = long_pos_q[POS_W-1] ? '0 : long_pos_q[FRAC_BITS +: COORD_BITS];
  assign short_int = short_eff[POS_W-1] ? '0 : short_eff[FRAC_BITS +: COORD_BITS];
  assign span_lo   = (long_int > short_int) ? short_int : long_int;
  assign span_hi   = (long_int > short_int) ? long_int : short_int;
  assign last_row  = cur_row_q == end_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.init) begin
        busy_q <= 1'b1;
      end else if (ctl_i.drop || (ctl_i.emit && last_row)) begin
        busy_q <= 1'b0;
      end
      if (ctl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= in_opcode_i;
      xa_q       <= in_vx_a_i;
      ya_q       <= in_vy_a_i;
      xb_q       <= in_vx_b_i;
      yb_q       <= in_vy_b_i;
      xc_q       <= in_vx_c_i;
      yc_q       <= in_vy_c_i;
      paint_in_q <= in_paint_i;
    end else begin
      // swap only when the later row is strictly smaller
      unique case (ctl_i.vop)
        tsf_pkg::VOP_NONE: begin
        end
        tsf_pkg::VOP_SWAP_AB: begin
          if (yb_q < ya_q) begin
            xa_q <= xb_q; ya_q <= yb_q; xb_q <= xa_q; yb_q <= ya_q;
          end
        end
        tsf_pkg::VOP_SWAP_AC: begin
          if (yc_q < ya_q) begin
            xa_q <= xc_q; ya_q <= yc_q; xc_q <= xa_q; yc_q <= ya_q;
          end
        end
        tsf_pkg::VOP_SWAP_BC: begin
          if (yc_q < yb_q) begin
            xb_q <= xc_q; yb_q <= yc_q; xc_q <= xb_q; yc_q <= yb_q;
          end
        end
      endcase
    end

    unique case (ctl_i.slope_wr)
      tsf_pkg::SL_NONE: begin
      end
      tsf_pkg::SL_LONG:  long_slope_q  <= quot;
      tsf_pkg::SL_UPPER: upper_slope_q <= quot;
      tsf_pkg::SL_LOWER: lower_slope_q <= quot;
    endcase

    if (ctl_i.init) begin
      long_pos_q   <= $signed({2'b00, xa_q, {FRAC_BITS{1'b0}}});
      short_pos_q  <= $signed({2'b00, xa_q, {FRAC_BITS{1'b0}}});
      cur_row_q    <= ya_q;
      mid_row_q    <= yb_q;
      end_row_q    <= yc_q;
      mid_col_q    <= xb_q;
      fill_paint_q <= paint_in_q;
    end else if (ctl_i.emit) begin
      long_pos_q  <= long_pos_q + long_slope_q;
      short_pos_q <= short_eff + ((cur_row_q < mid_row_q) ? upper_slope_q : lower_slope_q);
      if (!last_row) begin
        cur_row_q <= cur_row_q + 1'b1;
      end
    end

    if (ctl_i.emit) begin
      row_out_q   <= cur_row_q;
      left_out_q  <= span_lo;
      width_out_q <= {1'b0, span_hi} - {1'b0, span_lo} + 1'b1;
      paint_out_q <= fill_paint_q;
      final_out_q <= last_row;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign span_row_o   = row_out_q;
  assign span_left_o  = left_out_q;
  assign span_width_o = width_out_q;
  assign span_paint_o = paint_out_q;
  assign final_span_o = final_out_q;

endmodule
`default_nettype wire

@@ rtl/triangle_scanline_filler_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_scanline_filler_unit
// Scanline fill of one flat-shaded triangle: a load sorts the vertices and
// works out three fixed-point edge slopes, each busy step gives one span.
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  --------+-----+--------------------------------------------------------
//  in_i    | in  | opcode 0: load vertices and paint; opcode 1: next span
//  out_o   | out | one span: row, left column, width, paint, final flag
//
//  A load runs the three slope divisions one after another on the one
//  bit-serial divider, which a dropped (flat) triangle skips; a step passes
//  the dispatch and span steps and emits, or returns to wait while idle.
//  Items are taken one at a time, only at the wait step of the microcode.
//  A span waits in the output register; a new item is not taken while it
//  is held and not taken in that cycle. Reset clears busy and the output valid.
// ----------------------------------------------------------------------------
module triangle_scanline_filler_unit #(
  parameter int COORD_BITS = 8,
  parameter int FRAC_BITS  = 6
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tsf_in_if.sink     in_i,
  tsf_out_if.source  out_o
);

  tsf_pkg::ctl_word_t   ctl;
  tsf_pkg::seq_status_t status;

  tsf_sequencer u_sequencer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctl_o    (ctl)
  );

  tsf_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .status_o     (status),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_opcode_i  (in_i.opcode),
    .in_vx_a_i    (in_i.vx_a),
    .in_vy_a_i    (in_i.vy_a),
    .in_vx_b_i    (in_i.vx_b),
    .in_vy_b_i    (in_i.vy_b),
    .in_vx_c_i    (in_i.vx_c),
    .in_vy_c_i    (in_i.vy_c),
    .in_paint_i   (in_i.paint),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .span_row_o   (out_o.span_row),
    .span_left_o  (out_o.span_left),
    .span_width_o (out_o.span_width),
    .span_paint_o (out_o.span_paint),
    .final_span_o (out_o.final_span)
  );

endmodule
`default_nettype wire

@@ test/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle scanline filler. Loads and span
// requests are queued up front and fed through the command channel with
// random gaps; a predictor follows each accepted transaction and keeps the
// spans due, which are checked in order as they leave the span channel
// under random back-pressure.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 8;
  localparam int FRAC_BITS  = 6;

  typedef struct packed {
    tsf_pkg::opcode_e               op;
    logic [COORD_BITS-1:0]          xa;
    logic [COORD_BITS-1:0]          ya;
    logic [COORD_BITS-1:0]          xb;
    logic [COORD_BITS-1:0]          yb;
    logic [COORD_BITS-1:0]          xc;
    logic [COORD_BITS-1:0]          yc;
    logic [tsf_pkg::PAINT_W-1:0]    paint;
    logic                           drain;
  } raster_cmd_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]          row;
    logic [COORD_BITS-1:0]          left;
    logic [COORD_BITS:0]            width;
    logic [tsf_pkg::PAINT_W-1:0]    paint;
    logic                           last;
  } span_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tsf_in_if  #(.COORD_BITS(COORD_BITS)) in_if ();
  tsf_out_if #(.COORD_BITS(COORD_BITS)) out_if ();

  triangle_scanline_filler_unit #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  raster_cmd_t pending_cmds[$];
  span_t       spans_due[$];
  int          n_bad = 0;

  // predictor state
  logic                         tri_busy = 1'b0;
  logic [COORD_BITS-1:0]        row_cur = '0, row_mid = '0, row_end = '0, col_mid = '0;
  int                           long_pos = 0, short_pos = 0;
  int                           long_step = 0, upper_step = 0, lower_step = 0;
  logic [tsf_pkg::PAINT_W-1:0]  tri_paint = '0;

  function automatic int edge_step(input int xa, input int ya, input int xb, input int yb);
    if (yb == ya) return 0;
    // SV integer division truncates toward zero
    return ((xb - xa) * (1 << FRAC_BITS)) / (yb - ya);
  endfunction

  function automatic int whole_col(input int pos);
    if (pos < 0) return 0;
    return (pos >> FRAC_BITS) & ((1 << COORD_BITS) - 1);
  endfunction

  function void raster_command(input raster_cmd_t c);
    int    x0, y0, x1, y1, x2, y2, t;
    int    left_col, right_col;
    span_t s;
    if (c.op == tsf_pkg::OP_LOAD) begin
      x0 = int'(c.xa); y0 = int'(c.ya);
      x1 = int'(c.xb); y1 = int'(c.yb);
      x2 = int'(c.xc); y2 = int'(c.yc);
      if (y1 < y0) begin t = y0; y0 = y1; y1 = t; t = x0; x0 = x1; x1 = t; end
      if (y2 < y0) begin t = y0; y0 = y2; y2 = t; t = x0; x0 = x2; x2 = t; end
      if (y2 < y1) begin t = y1; y1 = y2; y2 = t; t = x1; x1 = x2; x2 = t; end
      if (y0 == y2) begin
        tri_busy = 1'b0;
        return;
      end
      long_step  = edge_step(x0, y0, x2, y2);
      upper_step = edge_step(x0, y0, x1, y1);
      lower_step = edge_step(x1, y1, x2, y2);
      long_pos   = x0 << FRAC_BITS;
      short_pos  = long_pos;
      row_cur    = COORD_BITS'(y0);
      row_mid    = COORD_BITS'(y1);
      row_end    = COORD_BITS'(y2);
      col_mid    = COORD_BITS'(x1);
      tri_paint  = c.paint;
      tri_busy   = 1'b1;
    end else if (tri_busy) begin
      // restart the short edge at the middle vertex
      if (row_cur == row_mid) short_pos = int'(col_mid) << FRAC_BITS;
      left_col  = whole_col(long_pos);
      right_col = whole_col(short_pos);
      if (left_col > right_col) begin
        t = left_col; left_col = right_col; right_col = t;
      end
      s.row   = row_cur;
      s.left  = COORD_BITS'(left_col);
      s.width = (COORD_BITS+1)'(right_col - left_col + 1);
      s.paint = tri_paint;
      s.last  = (row_cur == row_end);
      spans_due.push_back(s);
      long_pos  += long_step;
      short_pos += (row_cur < row_mid) ? upper_step : lower_step;
      if (s.last) tri_busy = 1'b0;
      else row_cur = row_cur + 1'b1;
    end
  endfunction

  function automatic int idle_span();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_load(input int xa, input int ya, input int xb, input int yb,
                          input int xc, input int yc, input int paint, input bit drain);
    raster_cmd_t c;
    c.op = tsf_pkg::OP_LOAD;
    c.xa = COORD_BITS'(xa); c.ya = COORD_BITS'(ya);
    c.xb = COORD_BITS'(xb); c.yb = COORD_BITS'(yb);
    c.xc = COORD_BITS'(xc); c.yc = COORD_BITS'(yc);
    c.paint = tsf_pkg::PAINT_W'(paint);
    c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  task automatic add_steps(input int n);
    raster_cmd_t c;
    c = '0;
    c.op = tsf_pkg::OP_STEP;
    // leftover payload bits are don't-care on a step
    c.xa = COORD_BITS'($urandom);
    c.ya = COORD_BITS'($urandom);
    c.paint = tsf_pkg::PAINT_W'($urandom);
    repeat (n) pending_cmds.push_back(c);
  endtask

  // ---------------------------------------------------------------- driver
  int send_gap;
  bit send_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.opcode <= tsf_pkg::OP_STEP;
      in_if.vx_a   <= '0;
      in_if.vy_a   <= '0;
      in_if.vx_b   <= '0;
      in_if.vy_b   <= '0;
      in_if.vx_c   <= '0;
      in_if.vy_c   <= '0;
      in_if.paint  <= '0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        raster_command(pending_cmds[0]);
        void'(pending_cmds.pop_front());
        if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : idle_span();
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the transaction until taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].drain && spans_due.size() != 0)) begin
        in_if.valid  <= 1'b1;
        in_if.opcode <= pending_cmds[0].op;
        in_if.vx_a   <= pending_cmds[0].xa;
        in_if.vy_a   <= pending_cmds[0].ya;
        in_if.vx_b   <= pending_cmds[0].xb;
        in_if.vy_b   <= pending_cmds[0].yb;
        in_if.vx_c   <= pending_cmds[0].xc;
        in_if.vy_c   <= pending_cmds[0].yc;
        in_if.paint  <= pending_cmds[0].paint;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- monitor
  int    take_gap;
  bit    take_calm = 1'b0;
  span_t got_span, want_span;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_span = {out_if.span_row, out_if.span_left, out_if.span_width,
                    out_if.span_paint, out_if.final_span};
        if (spans_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: span with none due: row %0d left %0d width %0d paint %0d last %0d",
                     $realtime, got_span.row, got_span.left, got_span.width,
                     got_span.paint, got_span.last);
        end else begin
          want_span = spans_due.pop_front();
          if (got_span !== want_span) begin
            n_bad++;
            if (n_bad <= 10)
              $display({"%0t: span mismatch (exp/got): row %0d/%0d left %0d/%0d",
                        " width %0d/%0d paint %0d/%0d last %0d/%0d"},
                       $realtime, want_span.row, got_span.row,
                       want_span.left, got_span.left,
                       want_span.width, got_span.width,
                       want_span.paint, got_span.paint,
                       want_span.last, got_span.last);
          end
        end
      end
      if ($urandom_range(0, 299) == 0) take_calm = !take_calm;
      if (take_gap > 0) take_gap--;
      else if (!take_calm && $urandom_range(0, 7) == 0) take_gap = idle_span();
      out_if.ready <= (take_gap == 0);
    end
  end

  // -------------------------------------------------------------- stimulus
  initial begin
    int h, lo, hi, md, ya, yb, yc, n_steps;
    raster_cmd_t c;

    rst_ni = 1'b1;

    // step while idle: nothing comes out
    add_steps(1);
    // all three rows equal: dropped, the following step gives nothing
    add_load(0, 9, 255, 9, 128, 9, 15, 1'b0);
    add_steps(1);
    // full height with a flat top and equal rows in the sort; replaced early
    add_load(255, 255, 0, 0, 128, 0, 0, 1'b0);
    add_steps(4);
    // flat bottom, then one step past the end
    add_load(10, 20, 30, 23, 20, 23, 5, 1'b0);
    add_steps(5);
    // middle vertex left of the long edge; wait for every span due first
    add_load(60, 40, 40, 42, 70, 44, 10, 1'b1);
    add_steps(5);

    while (pending_cmds.size() < 1500) begin
      if ($urandom_range(0, 99) < 85) begin
        md = $urandom_range(0, 99);
        if (md < 3) h = $urandom_range(100, 255);
        else if (md < 10) h = 0;
        else h = $urandom_range(1, 12);
        lo = $urandom_range(0, 255 - h);
        hi = lo + h;
        md = $urandom_range(lo, hi);
        case ($urandom_range(0, 5))
          0: begin ya = lo; yb = md; yc = hi; end
          1: begin ya = lo; yb = hi; yc = md; end
          2: begin ya = md; yb = lo; yc = hi; end
          3: begin ya = md; yb = hi; yc = lo; end
          4: begin ya = hi; yb = lo; yc = md; end
          default: begin ya = hi; yb = md; yc = lo; end
        endcase
        add_load($urandom_range(0, 255), ya, $urandom_range(0, 255), yb,
                 $urandom_range(0, 255), yc, $urandom_range(0, 15),
                 pending_cmds.size() == 20 || $urandom_range(0, 39) == 0);
        // now and then cut the triangle short, otherwise run to the end or past it
        if ($urandom_range(0, 9) == 0) n_steps = $urandom_range(0, h);
        else n_steps = h + 1 + $urandom_range(0, 2);
        add_steps(n_steps);
      end else begin
        c.op    = ($urandom_range(0, 1) == 0) ? tsf_pkg::OP_LOAD : tsf_pkg::OP_STEP;
        c.xa    = COORD_BITS'($urandom);
        c.ya    = COORD_BITS'($urandom);
        c.xb    = COORD_BITS'($urandom);
        c.yb    = COORD_BITS'($urandom);
        c.xc    = COORD_BITS'($urandom);
        c.yc    = COORD_BITS'($urandom);
        c.paint = tsf_pkg::PAINT_W'($urandom);
        c.drain = 1'b0;
        pending_cmds.push_back(c);
      end
    end

    #1;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || spans_due.size() != 0) @(posedge clk_i);
    // a trailing load may still be dividing
    repeat (64) @(posedge clk_i);

    if (n_bad == 0 && spans_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
